>>> rtl/slotted_page_manager_top_macros.svh
// Assertion helpers used by the top-level RTL file of the slotted page manager.
`ifndef SLOTTED_PAGE_MANAGER_TOP_MACROS_SVH
`define SLOTTED_PAGE_MANAGER_TOP_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define SPM_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define SPM_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/spm_pkg.sv
package spm_pkg;

  localparam int PAGE_BYTES   = 4096;
  localparam int HEADER_BYTES = 16;
  localparam int SLOT_BYTES   = 4;
  localparam int MAX_SLOTS    = 1024;

  localparam int PAGE_AW = 12;
  localparam int SLOT_AW = 10;
  localparam int LEN_W   = 13;
  localparam int CNT_W   = 11;
  localparam int ALU_W   = 14;

  localparam logic [2:0] REQ_INSERT  = 3'd0;
  localparam logic [2:0] REQ_UPDATE  = 3'd1;
  localparam logic [2:0] REQ_PAYLOAD = 3'd2;
  localparam logic [2:0] REQ_READ    = 3'd3;
  localparam logic [2:0] REQ_DELETE  = 3'd4;
  localparam logic [2:0] REQ_PEEK    = 3'd5;
  localparam logic [2:0] REQ_FORMAT  = 3'd6;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOSPACE  = 3'd1;
  localparam logic [2:0] ST_BADSLOT  = 3'd2;
  localparam logic [2:0] ST_DELETED  = 3'd3;
  localparam logic [2:0] ST_IGNORED  = 3'd4;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [9:0]  slot_id;
    logic [12:0] tuple_size;
    logic [7:0]  data_byte;
    logic [11:0] byte_addr;
  } spm_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  slot_num;
    logic [12:0] tuple_offset;
    logic [12:0] tuple_length;
    logic [7:0]  byte_out;
  } spm_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_PEEK,
    S_SLOT,
    S_FREE,
    S_CHK,
    S_CS_RD,
    S_CS_CHK,
    S_CP_RD,
    S_CP_WR,
    S_CB_RD,
    S_CB_WR,
    S_DONE
  } spm_state_t;

endpackage

>>> rtl/spm_ram.sv
module spm_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> rtl/spm_alu.sv
// Shared subtract and compare unit: diff = a - b, borrow when a < b.
module spm_alu
  import spm_pkg::*;
(
  input  logic [ALU_W-1:0] a,
  input  logic [ALU_W-1:0] b,
  output logic [ALU_W-1:0] diff,
  output logic             borrow
);

  logic [ALU_W:0] full;

  assign full   = {1'b0, a} - {1'b0, b};
  assign diff   = full[ALU_W-1:0];
  assign borrow = full[ALU_W];

endmodule

>>> rtl/slotted_page_manager_top.sv
// Channel | Direction | Handshake          | Payload
// req     | in        | req_valid/req_stall | spm_in_t: one command or payload byte
// rsp     | out       | rsp_valid/rsp_stall | spm_out_t: one result per transaction
//
// A delete, or an update that runs short of space, compacts the page: the sequencer walks
// the directory slots, copies each live tuple into the scratch memory, and then copies
// the bytes between the new data floor and the page top back into the page memory.
// Each memory has a single port, and one subtractor is shared by all the steps.
// Reset clears the directory pointers and counters; page and slot memories are
// left as they are. req_stall is low only while the sequencer is idle; a result
// waiting on rsp_stall does not block intake of the next transaction.
`include "slotted_page_manager_top_macros.svh"

module slotted_page_manager_top
  import spm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  spm_in_t  req,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output spm_out_t rsp
);

  spm_state_t state, state_next;
  spm_in_t    cmd, cmd_next;
  spm_out_t   res, res_next;
  spm_out_t   rsp_next;
  logic       rsp_valid_next;

  logic [CNT_W-1:0] slot_count, slot_count_next;
  logic [LEN_W-1:0] directory_end, directory_end_next;
  logic [LEN_W-1:0] data_floor, data_floor_next;
  logic [LEN_W-1:0] write_cursor, write_cursor_next;
  logic [LEN_W-1:0] payload_left, payload_left_next;
  logic [LEN_W-1:0] free_r, free_r_next;
  logic [CNT_W-1:0] cidx, cidx_next;
  logic [LEN_W-1:0] top, top_next;
  logic [LEN_W-1:0] clen, clen_next;
  logic [LEN_W-1:0] csrc, csrc_next;
  logic [LEN_W-1:0] k, k_next;
  logic             compacted, compacted_next;

  // Memory ports.
  logic [PAGE_AW-1:0] page_addr, scr_addr;
  logic               page_we, scr_we;
  logic [7:0]         page_wd, page_rd, scr_wd, scr_rd;
  logic [SLOT_AW-1:0] offs_addr, lens_addr;
  logic               offs_we, lens_we;
  logic [LEN_W-1:0]   offs_wd, offs_rd, lens_wd, lens_rd;

  // Shared subtractor.
  logic [ALU_W-1:0] alu_a, alu_b, alu_diff;
  logic             alu_borrow;

  logic [LEN_W-1:0] k_inc;
  logic [ALU_W-1:0] src_end;
  logic [LEN_W-1:0] new_off;

  spm_ram #(.DEPTH(PAGE_BYTES), .WIDTH(8)) u_page (
    .clk(clk), .addr(page_addr), .we(page_we), .wdata(page_wd), .rdata(page_rd)
  );
  spm_ram #(.DEPTH(PAGE_BYTES), .WIDTH(8)) u_scratch (
    .clk(clk), .addr(scr_addr), .we(scr_we), .wdata(scr_wd), .rdata(scr_rd)
  );
  spm_ram #(.DEPTH(MAX_SLOTS), .WIDTH(LEN_W)) u_offs (
    .clk(clk), .addr(offs_addr), .we(offs_we), .wdata(offs_wd), .rdata(offs_rd)
  );
  spm_ram #(.DEPTH(MAX_SLOTS), .WIDTH(LEN_W)) u_lens (
    .clk(clk), .addr(lens_addr), .we(lens_we), .wdata(lens_wd), .rdata(lens_rd)
  );

  spm_alu u_alu (.a(alu_a), .b(alu_b), .diff(alu_diff), .borrow(alu_borrow));

  assign req_stall = (state != S_IDLE);
  assign k_inc     = k + LEN_W'(1);
  assign src_end   = {1'b0, offs_rd} + {1'b0, lens_rd};
  assign new_off   = data_floor - cmd.tuple_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      rsp_valid     <= 1'b0;
      slot_count    <= '0;
      directory_end <= LEN_W'(HEADER_BYTES);
      data_floor    <= LEN_W'(PAGE_BYTES);
      write_cursor  <= '0;
      payload_left  <= '0;
      compacted     <= 1'b0;
    end else begin
      state         <= state_next;
      rsp_valid     <= rsp_valid_next;
      slot_count    <= slot_count_next;
      directory_end <= directory_end_next;
      data_floor    <= data_floor_next;
      write_cursor  <= write_cursor_next;
      payload_left  <= payload_left_next;
      compacted     <= compacted_next;
    end
    cmd    <= cmd_next;
    res    <= res_next;
    rsp    <= rsp_next;
    free_r <= free_r_next;
    cidx   <= cidx_next;
    top    <= top_next;
    clen   <= clen_next;
    csrc   <= csrc_next;
    k      <= k_next;
  end

  always_comb begin
    state_next         = state;
    cmd_next           = cmd;
    res_next           = res;
    rsp_next           = rsp;
    rsp_valid_next     = rsp_valid && rsp_stall;
    slot_count_next    = slot_count;
    directory_end_next = directory_end;
    data_floor_next    = data_floor;
    write_cursor_next  = write_cursor;
    payload_left_next  = payload_left;
    free_r_next        = free_r;
    cidx_next          = cidx;
    top_next           = top;
    clen_next          = clen;
    csrc_next          = csrc;
    k_next             = k;
    compacted_next     = compacted;
    page_addr = '0; page_we = 1'b0; page_wd = '0;
    scr_addr  = '0; scr_we  = 1'b0; scr_wd  = '0;
    offs_addr = '0; offs_we = 1'b0; offs_wd = '0;
    lens_addr = '0; lens_we = 1'b0; lens_wd = '0;
    alu_a = '0;
    alu_b = '0;

    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd_next   = req;
          state_next = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        res_next   = '0;
        state_next = S_DONE;
        if (cmd.req_type == REQ_PAYLOAD) begin
          if (payload_left == '0 || write_cursor >= LEN_W'(PAGE_BYTES)) begin
            payload_left_next = '0;
            res_next.status   = ST_IGNORED;
          end else begin
            page_addr = write_cursor[PAGE_AW-1:0];
            page_we   = 1'b1;
            page_wd   = cmd.data_byte;
            res_next.tuple_offset = write_cursor;
            res_next.tuple_length = payload_left - LEN_W'(1);
            write_cursor_next = write_cursor + LEN_W'(1);
            payload_left_next = payload_left - LEN_W'(1);
          end
        end else if (cmd.req_type <= REQ_FORMAT) begin
          payload_left_next = '0;
          case (cmd.req_type)
            REQ_INSERT: begin
              if (slot_count >= CNT_W'(MAX_SLOTS)) begin
                res_next.status = ST_NOSPACE;
              end else begin
                state_next = S_FREE;
              end
            end
            REQ_PEEK: begin
              page_addr  = cmd.byte_addr;
              state_next = S_PEEK;
            end
            REQ_FORMAT: begin
              slot_count_next    = '0;
              directory_end_next = LEN_W'(HEADER_BYTES);
              data_floor_next    = LEN_W'(PAGE_BYTES);
            end
            default: begin
              // Update, read and delete address an existing slot.
              res_next.slot_num = cmd.slot_id;
              if (CNT_W'(cmd.slot_id) >= slot_count) begin
                res_next.status = ST_BADSLOT;
              end else begin
                offs_addr  = cmd.slot_id;
                lens_addr  = cmd.slot_id;
                state_next = S_SLOT;
              end
            end
          endcase
        end
      end

      S_PEEK: begin
        res_next.byte_out = page_rd;
        state_next        = S_DONE;
      end

      S_SLOT: begin
        state_next = S_DONE;
        if (lens_rd == '0) begin
          res_next.status = ST_DELETED;
        end else if (cmd.req_type == REQ_READ) begin
          res_next.tuple_offset = offs_rd;
          res_next.tuple_length = lens_rd;
        end else if (cmd.req_type == REQ_DELETE) begin
          lens_addr  = cmd.slot_id;
          lens_we    = 1'b1;
          lens_wd    = '0;
          cidx_next  = '0;
          top_next   = LEN_W'(PAGE_BYTES);
          state_next = S_CS_RD;
        end else if (cmd.tuple_size <= lens_rd) begin
          // The new tuple fits where the old one is.
          lens_addr = cmd.slot_id;
          lens_we   = 1'b1;
          lens_wd   = cmd.tuple_size;
          write_cursor_next = offs_rd;
          payload_left_next = cmd.tuple_size;
          res_next.tuple_offset = offs_rd;
          res_next.tuple_length = cmd.tuple_size;
        end else begin
          compacted_next = 1'b0;
          state_next     = S_FREE;
        end
      end

      S_FREE: begin
        alu_a       = ALU_W'(data_floor);
        alu_b       = ALU_W'(directory_end);
        free_r_next = alu_borrow ? '0 : alu_diff[LEN_W-1:0];
        state_next  = S_CHK;
      end

      S_CHK: begin
        alu_a = ALU_W'(free_r);
        alu_b = ALU_W'(cmd.tuple_size)
              + ((cmd.req_type == REQ_INSERT) ? ALU_W'(SLOT_BYTES) : '0);
        state_next = S_DONE;
        if (!alu_borrow) begin
          data_floor_next   = new_off;
          write_cursor_next = new_off;
          payload_left_next = cmd.tuple_size;
          offs_we = 1'b1;
          offs_wd = new_off;
          lens_we = 1'b1;
          lens_wd = cmd.tuple_size;
          res_next.tuple_offset = new_off;
          res_next.tuple_length = cmd.tuple_size;
          if (cmd.req_type == REQ_INSERT) begin
            offs_addr = slot_count[SLOT_AW-1:0];
            lens_addr = slot_count[SLOT_AW-1:0];
            res_next.slot_num  = slot_count[SLOT_AW-1:0];
            slot_count_next    = slot_count + CNT_W'(1);
            directory_end_next = directory_end + LEN_W'(SLOT_BYTES);
          end else begin
            offs_addr = cmd.slot_id;
            lens_addr = cmd.slot_id;
          end
        end else if (cmd.req_type == REQ_UPDATE && !compacted) begin
          compacted_next = 1'b1;
          cidx_next      = '0;
          top_next       = LEN_W'(PAGE_BYTES);
          state_next     = S_CS_RD;
        end else begin
          res_next.status = ST_NOSPACE;
        end
      end

      S_CS_RD: begin
        if (cidx == slot_count) begin
          k_next     = top;
          state_next = S_CB_RD;
        end else begin
          offs_addr  = cidx[SLOT_AW-1:0];
          lens_addr  = cidx[SLOT_AW-1:0];
          state_next = S_CS_CHK;
        end
      end

      S_CS_CHK: begin
        alu_a     = ALU_W'(top);
        alu_b     = ALU_W'(lens_rd);
        clen_next = lens_rd;
        csrc_next = offs_rd;
        if (lens_rd == '0 || alu_borrow || src_end > ALU_W'(PAGE_BYTES)) begin
          cidx_next  = cidx + CNT_W'(1);
          state_next = S_CS_RD;
        end else begin
          top_next   = alu_diff[LEN_W-1:0];
          k_next     = '0;
          state_next = S_CP_RD;
        end
      end

      S_CP_RD: begin
        page_addr  = PAGE_AW'(csrc + k);
        state_next = S_CP_WR;
      end

      S_CP_WR: begin
        scr_addr = PAGE_AW'(top + k);
        scr_we   = 1'b1;
        scr_wd   = page_rd;
        k_next   = k_inc;
        if (k_inc == clen) begin
          offs_addr  = cidx[SLOT_AW-1:0];
          offs_we    = 1'b1;
          offs_wd    = top;
          cidx_next  = cidx + CNT_W'(1);
          state_next = S_CS_RD;
        end else begin
          state_next = S_CP_RD;
        end
      end

      S_CB_RD: begin
        if (k >= LEN_W'(PAGE_BYTES)) begin
          data_floor_next = top;
          if (cmd.req_type == REQ_DELETE) begin
            state_next = S_DONE;
          end else begin
            state_next = S_FREE;
          end
        end else begin
          scr_addr   = k[PAGE_AW-1:0];
          state_next = S_CB_WR;
        end
      end

      S_CB_WR: begin
        page_addr  = k[PAGE_AW-1:0];
        page_we    = 1'b1;
        page_wd    = scr_rd;
        k_next     = k_inc;
        state_next = S_CB_RD;
      end

      S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_next       = res;
          rsp_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // The directory grows by one slot entry per slot in use.
  `SPM_ALWAYS(a_dir_end, directory_end == LEN_W'(HEADER_BYTES + SLOT_BYTES * int'(slot_count)), "directory end out of step with slot count")
  // Tuple space never overlaps the directory.
  `SPM_ALWAYS(a_floor, data_floor >= directory_end, "data floor below directory end")
  `SPM_ALWAYS(a_count, slot_count <= CNT_W'(MAX_SLOTS), "slot count beyond capacity")
  // A finished result is handed to the output register once it is free.
  `SPM_NEXT(a_deliver, state == S_DONE && (!rsp_valid || !rsp_stall), rsp_valid && state == S_IDLE, "result not delivered")

endmodule

>>> dv/slotted_page_manager_top_tb.sv
`timescale 1ns / 100ps

module slotted_page_manager_top_tb
  import spm_pkg::*;
;

  localparam logic [2:0] REQ_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 60000000;
  localparam int LONG_HOLD   = 3000;
  localparam int MAX_PAYLOAD = 40;

  typedef struct {
    spm_in_t  cmd;
    spm_out_t want;
    bit       drain;
  } page_job_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_stall;
  spm_in_t  req = '0;
  logic     rsp_valid;
  logic     rsp_stall = 1'b0;
  spm_out_t rsp;

  slotted_page_manager_top u_top (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always #5 clk = ~clk;

  // Transactions waiting to be offered, and results owed by accepted ones.
  page_job_t pending_jobs[$];
  spm_out_t  owed_results[$];
  int        fail_count = 0;
  int        accepted_count = 0;
  bit        stimulus_done = 1'b0;
  int        cycle_count = 0;

  // Shadow of the page. The byte_known flags follow which page bytes hold data
  // that was really written, so that a peek never lands on an unwritten byte.
  int page_byte[PAGE_BYTES];
  bit byte_known[PAGE_BYTES];
  int scratch_byte[PAGE_BYTES];
  bit scratch_known[PAGE_BYTES];
  int slot_off[MAX_SLOTS];
  int slot_len[MAX_SLOTS];
  int n_slots;
  int dir_end;
  int floor_ptr;
  int cursor;
  int bytes_owed;

  function automatic int free_space();
    return (floor_ptr >= dir_end) ? floor_ptr - dir_end : 0;
  endfunction

  // Pack all live tuples against the page top, in slot order.
  function automatic void squeeze_page();
    int top;
    int len;
    int src;
    top = PAGE_BYTES;
    for (int i = 0; i < n_slots && i < MAX_SLOTS; i++) begin
      len = slot_len[i];
      src = slot_off[i];
      if (len == 0 || len > top || src > PAGE_BYTES || len > PAGE_BYTES - src) continue;
      top -= len;
      for (int k = 0; k < len; k++) begin
        scratch_byte[top + k]  = page_byte[src + k];
        scratch_known[top + k] = byte_known[src + k];
      end
      slot_off[i] = top;
    end
    for (int k = top; k < PAGE_BYTES; k++) begin
      page_byte[k]  = scratch_byte[k];
      byte_known[k] = scratch_known[k];
    end
    floor_ptr = top;
  endfunction

  function automatic spm_out_t page_result(logic [2:0] st, int sl, int off, int len, int b);
    spm_out_t r;
    r.status       = st;
    r.slot_num     = sl[9:0];
    r.tuple_offset = off[12:0];
    r.tuple_length = len[12:0];
    r.byte_out     = b[7:0];
    return r;
  endfunction

  // Apply one command to the shadow page and return the result it must give.
  function automatic spm_out_t apply_command(spm_in_t c);
    int sid;
    int size;
    int off;
    sid  = c.slot_id;
    size = c.tuple_size;
    if (c.req_type == REQ_UNUSED) return '0;
    if (c.req_type == REQ_PAYLOAD) begin
      if (bytes_owed == 0 || cursor >= PAGE_BYTES) begin
        bytes_owed = 0;
        return page_result(ST_IGNORED, 0, 0, 0, 0);
      end
      page_byte[cursor]  = c.data_byte;
      byte_known[cursor] = 1'b1;
      off = cursor;
      cursor++;
      bytes_owed--;
      return page_result(ST_OK, 0, off, bytes_owed, 0);
    end
    bytes_owed = 0;
    case (c.req_type)
      REQ_INSERT: begin
        if (n_slots >= MAX_SLOTS || free_space() < size + SLOT_BYTES)
          return page_result(ST_NOSPACE, 0, 0, 0, 0);
        off = floor_ptr - size;
        slot_off[n_slots] = off;
        slot_len[n_slots] = size;
        floor_ptr = off;
        dir_end += SLOT_BYTES;
        cursor = off;
        bytes_owed = size;
        n_slots++;
        return page_result(ST_OK, n_slots - 1, off, size, 0);
      end
      REQ_PEEK: return page_result(ST_OK, 0, 0, 0, page_byte[c.byte_addr]);
      REQ_FORMAT: begin
        n_slots = 0;
        dir_end = HEADER_BYTES;
        floor_ptr = PAGE_BYTES;
        return '0;
      end
      default: ;
    endcase
    if (sid >= n_slots) return page_result(ST_BADSLOT, sid, 0, 0, 0);
    if (slot_len[sid] == 0) return page_result(ST_DELETED, sid, 0, 0, 0);
    if (c.req_type == REQ_READ) return page_result(ST_OK, sid, slot_off[sid], slot_len[sid], 0);
    if (c.req_type == REQ_DELETE) begin
      slot_len[sid] = 0;
      squeeze_page();
      return page_result(ST_OK, sid, 0, 0, 0);
    end
    // Update: shrink in place, or relocate below the data floor.
    if (size <= slot_len[sid]) begin
      slot_len[sid] = size;
    end else begin
      if (free_space() < size) begin
        squeeze_page();
        if (free_space() < size) return page_result(ST_NOSPACE, sid, 0, 0, 0);
      end
      floor_ptr -= size;
      slot_off[sid] = floor_ptr;
      slot_len[sid] = size;
    end
    cursor = slot_off[sid];
    bytes_owed = size;
    return page_result(ST_OK, sid, slot_off[sid], size, 0);
  endfunction

  function automatic void queue_cmd(spm_in_t c, bit drain = 1'b0);
    page_job_t j;
    j.cmd   = c;
    j.want  = apply_command(c);
    j.drain = drain;
    pending_jobs.push_back(j);
  endfunction

  function automatic spm_in_t make_cmd(logic [2:0] kind, int sid = 0, int size = 0,
                                       int b = 0, int addr = 0);
    spm_in_t c;
    c.req_type   = kind;
    c.slot_id    = sid[9:0];
    c.tuple_size = size[12:0];
    c.data_byte  = b[7:0];
    c.byte_addr  = addr[11:0];
    return c;
  endfunction

  // Payload bytes for a command: usually the full tuple, sometimes cut short
  // so that the next command cancels the rest, sometimes with stray extras.
  // Long tuples only get a leading part so the run keeps its item count.
  function automatic void queue_payload(int size);
    int n;
    int r;
    r = $urandom_range(0, 99);
    n = size;
    if (r < 15 && size > 0) n = $urandom_range(0, size - 1);
    else if (r >= 90) n = size + $urandom_range(1, 2);
    if (n > MAX_PAYLOAD) n = $urandom_range(0, MAX_PAYLOAD);
    for (int i = 0; i < n; i++) queue_cmd(make_cmd(REQ_PAYLOAD, 0, 0, $urandom_range(0, 255)));
  endfunction

  function automatic int pick_slot();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1023);
    return $urandom_range(0, n_slots);
  endfunction

  // Peek a page byte that is known to hold written data, or fall back to a read.
  function automatic void queue_peek();
    int a;
    a = $urandom_range(0, PAGE_BYTES - 1);
    for (int i = 0; i < PAGE_BYTES; i++) begin
      if (byte_known[(a + i) % PAGE_BYTES]) begin
        queue_cmd(make_cmd(REQ_PEEK, $urandom_range(0, 1023), $urandom_range(0, 8191),
                           $urandom_range(0, 255), (a + i) % PAGE_BYTES));
        return;
      end
    end
    queue_cmd(make_cmd(REQ_READ, pick_slot()));
  endfunction

  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(0, 16);
    if (r < 97) return $urandom_range(17, 200);
    if (r < 99) return $urandom_range(201, 4096);
    return $urandom_range(4097, 8191);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Stimulus: a directed opening, then random command sequences.
  initial begin
    int size;
    int r;
    spm_in_t c;
    for (int i = 0; i < PAGE_BYTES; i++) begin
      page_byte[i] = 0;
      byte_known[i] = 1'b0;
    end
    n_slots = 0;
    dir_end = HEADER_BYTES;
    floor_ptr = PAGE_BYTES;
    cursor = 0;
    bytes_owed = 0;

    // Directed: the page edges and every command kind and error path.
    queue_cmd(make_cmd(REQ_PAYLOAD, 0, 0, 8'hA5));              // payload with nothing pending
    queue_cmd(make_cmd(REQ_READ, 0));                           // slot out of range
    queue_cmd(make_cmd(REQ_INSERT, 0, 0));                      // zero length slot reads as deleted
    queue_cmd(make_cmd(REQ_READ, 0));
    queue_cmd(make_cmd(REQ_INSERT, 1023, 4));
    queue_cmd(make_cmd(REQ_PAYLOAD, 0, 0, 8'hFF));
    queue_cmd(make_cmd(REQ_PAYLOAD, 0, 0, 8'h00));
    queue_cmd(make_cmd(REQ_PAYLOAD, 0, 0, 8'h5A));
    queue_cmd(make_cmd(REQ_PAYLOAD, 0, 0, 8'hC3));
    queue_cmd(make_cmd(REQ_PAYLOAD, 0, 0, 8'h11));              // one byte too many
    queue_cmd(make_cmd(REQ_PEEK, 0, 0, 0, PAGE_BYTES - 1));
    queue_cmd(make_cmd(REQ_READ, 1));
    queue_cmd(make_cmd(REQ_UPDATE, 1, 2));                      // shrink in place
    queue_cmd(make_cmd(REQ_PAYLOAD, 0, 0, 8'h77));
    queue_cmd(make_cmd(REQ_UPDATE, 1, 3));                      // grow, relocated
    queue_cmd(make_cmd(REQ_PAYLOAD, 0, 0, 8'h88));
    queue_cmd(make_cmd(REQ_DELETE, 0));                         // deleted slot
    queue_cmd(make_cmd(REQ_INSERT, 0, 8191));                   // no space
    queue_cmd(make_cmd(REQ_UPDATE, 1, 4090));                   // no space even after compaction
    queue_cmd(make_cmd(REQ_UPDATE, 1, 4060));                   // fits without compaction
    queue_cmd(make_cmd(REQ_DELETE, 1));
    queue_cmd(make_cmd(REQ_UNUSED, 1023, 8191, 255, 4095));
    queue_cmd(make_cmd(REQ_FORMAT, 0, 0, 0, 0), 1'b1);          // sender waits for the drain

    while (pending_jobs.size() < 1250) begin
      if (floor_ptr < 2500 || n_slots > 48) queue_cmd(make_cmd(REQ_FORMAT));
      r = $urandom_range(0, 99);
      if (r < 30) begin
        size = pick_size();
        queue_cmd(make_cmd(REQ_INSERT, $urandom_range(0, 1023), size));
        queue_payload(size);
      end else if (r < 45) begin
        size = pick_size();
        queue_cmd(make_cmd(REQ_UPDATE, pick_slot(), size));
        queue_payload(size);
      end else if (r < 55) begin
        queue_cmd(make_cmd(REQ_READ, pick_slot()));
      end else if (r < 66) begin
        queue_cmd(make_cmd(REQ_DELETE, pick_slot()));
      end else if (r < 79) begin
        queue_peek();
      end else if (r < 83) begin
        queue_cmd(make_cmd(REQ_FORMAT), $urandom_range(0, 9) == 0);
      end else if (r < 88) begin
        queue_cmd(make_cmd(REQ_PAYLOAD, 0, 0, $urandom_range(0, 255)));
      end else if (r < 91) begin
        queue_cmd(make_cmd(REQ_UNUSED, $urandom_range(0, 1023), $urandom_range(0, 8191)));
      end else begin
        // Noise: every field random, except that a peek must hit written data.
        c = make_cmd($urandom_range(0, 7), $urandom_range(0, 1023), $urandom_range(0, 8191),
                     $urandom_range(0, 255), $urandom_range(0, 4095));
        if (c.req_type == REQ_PEEK) queue_peek();
        else queue_cmd(c);
      end
    end
    stimulus_done = 1'b1;
  end

  // Reset is held from the start and then released for good.
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  // Driver: offers the queued transactions with random gaps. A job marked
  // for draining is held back until every owed result has come back.
  int send_gap = 0;
  always @(posedge clk) begin
    logic    next_valid;
    spm_in_t next_req;
    int      gap;
    next_valid = req_valid;
    next_req   = req;
    gap        = send_gap;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        owed_results.push_back(pending_jobs[0].want);
        void'(pending_jobs.pop_front());
        accepted_count++;
        next_valid = 1'b0;
        gap = pick_gap();
      end
      if (!next_valid) begin
        if (gap > 0) begin
          gap--;
        end else if (pending_jobs.size() > 0 &&
                     !(pending_jobs[0].drain && owed_results.size() > 0)) begin
          next_valid = 1'b1;
          next_req   = pending_jobs[0].cmd;
        end
      end
    end
    send_gap  <= gap;
    req_valid <= next_valid;
    req       <= next_req;
  end

  // Monitor: checks each result against the oldest owed one and drives the
  // stall. Once, after a few hundred transactions, the receiver holds off for
  // a long stretch so that results back up into the block.
  int  hold_left = 0;
  bit  long_hold_done = 1'b0;
  always @(posedge clk) begin
    spm_out_t want;
    int       hold;
    bit       next_stall;
    hold = hold_left;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (owed_results.size() == 0) begin
        $error("result with nothing owed: %p", rsp);
        fail_count++;
      end else begin
        want = owed_results.pop_front();
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp.status);
          fail_count++;
        end
        if (rsp.slot_num !== want.slot_num) begin
          $error("slot_num: expected %0d, got %0d", want.slot_num, rsp.slot_num);
          fail_count++;
        end
        if (rsp.tuple_offset !== want.tuple_offset) begin
          $error("tuple_offset: expected %0d, got %0d", want.tuple_offset, rsp.tuple_offset);
          fail_count++;
        end
        if (rsp.tuple_length !== want.tuple_length) begin
          $error("tuple_length: expected %0d, got %0d", want.tuple_length, rsp.tuple_length);
          fail_count++;
        end
        if (rsp.byte_out !== want.byte_out) begin
          $error("byte_out: expected %0d, got %0d", want.byte_out, rsp.byte_out);
          fail_count++;
        end
      end
    end
    if (!long_hold_done && accepted_count >= 300) begin
      long_hold_done = 1'b1;
      hold = LONG_HOLD;
    end
    if (hold > 0) begin
      hold--;
      next_stall = 1'b1;
    end else if (accepted_count % 400 < 100) begin
      next_stall = 1'b0;                      // a stretch with no stalls at all
    end else begin
      hold = pick_gap();
      next_stall = hold > 0;
      if (hold > 0) hold--;
    end
    hold_left <= hold;
    rsp_stall <= next_stall;
  end

  // Guard against a hung block.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // End of test: all transactions sent and all results back, then a short tail.
  initial begin
    wait (stimulus_done);
    while (pending_jobs.size() > 0 || owed_results.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/spm_pkg.sv
rtl/spm_ram.sv
rtl/spm_alu.sv
rtl/slotted_page_manager_top.sv
dv/slotted_page_manager_top_tb.sv
